>>> hw/rtl/irlbp_pkg.sv
// Package for the learned IR blob parser: result type, header byte positions,
// key codes, carrier band bounds and the lookup functions. No dependencies.
package irlbp_pkg;

  localparam int unsigned MAX_TIMINGS = 256;

  localparam logic [9:0] POS_KEY      = 10'd0;
  localparam logic [9:0] POS_TYPE     = 10'd1;
  localparam logic [9:0] POS_FREQ_HI  = 10'd3;
  localparam logic [9:0] POS_FREQ_LO  = 10'd4;
  localparam logic [9:0] POS_COUNT_HI = 10'd5;
  localparam logic [9:0] POS_COUNT_LO = 10'd6;
  localparam logic [9:0] FRAME_BASE   = 10'd9;

  localparam logic [7:0] KEY_VOL_UP   = 8'h18;
  localparam logic [7:0] KEY_VOL_DOWN = 8'h19;
  localparam logic [7:0] KEY_MUTE     = 8'hA4;
  localparam logic [7:0] KEY_POWER    = 8'h1A;
  localparam logic [7:0] KEY_INPUT    = 8'hB2;

  localparam logic [2:0] SLOT_VOL_UP   = 3'd0;
  localparam logic [2:0] SLOT_VOL_DOWN = 3'd1;
  localparam logic [2:0] SLOT_MUTE     = 3'd2;
  localparam logic [2:0] SLOT_POWER    = 3'd3;
  localparam logic [2:0] SLOT_INPUT    = 3'd4;
  localparam logic [2:0] SLOT_NONE     = 3'd5;

  localparam logic [7:0] TYPE_REPORT = 8'd3;
  localparam logic [7:0] TYPE_TOGGLE = 8'd4;

  localparam logic [1:0] RPT_NONE   = 2'd0;
  localparam logic [1:0] RPT_REPORT = 2'd1;
  localparam logic [1:0] RPT_TOGGLE = 2'd2;

  localparam logic       KIND_HEADER = 1'b0;
  localparam logic       KIND_TIMING = 1'b1;

  // Reciprocal of ten scaled by 2^27, exact for dividends below 2^26.
  localparam logic [23:0] DIV10_MUL   = 24'hCCCCCD;
  localparam int unsigned DIV10_SHIFT = 27;

  localparam int unsigned TDATA_W = 56;

  typedef struct packed {
    logic        kind;
    logic [2:0]  slot;
    logic [5:0]  carrier_khz;
    logic [1:0]  repeat_mode;
    logic [8:0]  timing_count;
    logic [8:0]  timing_index;
    logic [20:0] timing_value;
    logic        in_repeat_frame;
    logic        bad_length;
    logic        last;
  } result_t;

  function automatic logic [2:0] key_slot(input logic [7:0] k);
    logic [2:0] s;
    case (k)
      KEY_VOL_UP:   s = SLOT_VOL_UP;
      KEY_VOL_DOWN: s = SLOT_VOL_DOWN;
      KEY_MUTE:     s = SLOT_MUTE;
      KEY_POWER:    s = SLOT_POWER;
      KEY_INPUT:    s = SLOT_INPUT;
      default:      s = SLOT_NONE;
    endcase
    return s;
  endfunction

  // Frequency is in units of 100 Hz; exact bounds fall back to 38 kHz.
  function automatic logic [7:0] carrier_band(input logic [15:0] f);
    logic [7:0] b;
    if (f > 16'd250 && f < 16'd300) b = 8'd27;
    else if (f > 16'd300 && f < 16'd320) b = 8'd31;
    else if (f > 16'd320 && f < 16'd340) b = 8'd33;
    else if (f > 16'd340 && f < 16'd370) b = 8'd36;
    else if (f > 16'd370 && f < 16'd390) b = 8'd38;
    else if (f > 16'd390 && f < 16'd410) b = 8'd40;
    else if (f > 16'd410 && f < 16'd550) b = 8'd56;
    else if (f > 16'd550 && f < 16'd570) b = 8'd0;
    else b = 8'd38;
    return b;
  endfunction

endpackage

>>> hw/rtl/ir_learn_blob_parser_top.sv
// A byte accepted is held in the input register and parsed from there; its result is
// registered in the output register, which drives the outputs and the result request.
// Throughput: one byte per cycle; a new byte is taken in every cycle unless
// the result register is full and stalled.
// Reset (rst_n low, synchronous) empties both registers and leaves the parser
// waiting for a byte with blob start set.
// Top level of the learned IR blob parser; uses irlbp_pkg.
module ir_learn_blob_parser_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic       in_tuser,   // [0] blob_start
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [irlbp_pkg::TDATA_W-1:0] out_tdata,
  // [2:0] slot, [8:3] carrier_khz, [10:9] repeat_mode, [19:11] timing_count,
  // [28:20] timing_index, [49:29] timing_value, [50] in_repeat_frame,
  // [51] bad_length, [55:52] zero
  output logic       out_tuser,  // [0] kind
  output logic       out_tlast   // [0] last
);
  import irlbp_pkg::*;

  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  logic        s1_start_r;
  logic        advance;

  logic [9:0]  pos_r, pos_nxt, pos_c;
  logic [23:0] asm_r, asm_nxt, asm_c, asm_new;
  logic [7:0]  key_r, key_nxt;
  logic [7:0]  type_r, type_nxt, type_c;
  logic [7:0]  freq_r, freq_nxt, freq_c;
  logic [8:0]  count_r, count_nxt, count_c;
  logic [8:0]  tcnt_r, tcnt_nxt, tcnt_c;
  logic        fin_r, fin_nxt, fin_c;

  logic [16:0] hdr_len;
  logic        hdr_bad;
  logic [9:0]  r_off, two_len, q_off;
  logic        in_main;
  logic        end_word, end_fill;
  logic [23:0] div_src;
  logic [47:0] div_prod;
  logic        res_valid;
  result_t     res;

  logic        out_valid_r;
  result_t     out_r;

  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r  <= in_tdata;
      s1_start_r <= in_tuser;
    end
  end

  assign pos_c   = s1_start_r ? '0 : pos_r;
  assign asm_c   = s1_start_r ? '0 : asm_r;
  assign type_c  = s1_start_r ? '0 : type_r;
  assign freq_c  = s1_start_r ? '0 : freq_r;
  assign count_c = s1_start_r ? '0 : count_r;
  assign tcnt_c  = s1_start_r ? '0 : tcnt_r;
  assign fin_c   = s1_start_r ? 1'b0 : fin_r;

  assign asm_new  = {asm_c[15:0], s1_byte_r};
  assign hdr_len  = {asm_c[7:0], s1_byte_r, 1'b0};
  assign hdr_bad  = (hdr_len < 17'd4) || (hdr_len > 17'(MAX_TIMINGS));
  assign r_off    = pos_c - FRAME_BASE;
  assign two_len  = {count_c, 1'b0};
  assign q_off    = r_off - two_len;
  assign in_main  = r_off < two_len;
  assign div_src  = end_fill ? {asm_new[15:0], 8'h00} : asm_new;
  assign div_prod = {24'd0, div_src} * {24'd0, DIV10_MUL};

  always_comb begin
    end_word = 1'b0;
    end_fill = 1'b0;
    if (in_main) begin
      if (r_off == 10'd2 || r_off == 10'd4) begin
        end_word = 1'b1;
      end else if (r_off == two_len - 10'd3 || r_off == two_len - 10'd1) begin
        end_fill = 1'b1;
      end else if (r_off >= 10'd5 && r_off < two_len - 10'd3 && !r_off[0]) begin
        end_word = 1'b1;
      end
    end else begin
      if (q_off == 10'd2 || q_off == 10'd4) begin
        end_word = 1'b1;
      end else if (q_off == 10'd5 || q_off == 10'd7) begin
        end_fill = 1'b1;
      end
    end
  end

  always_comb begin
    pos_nxt   = pos_c;
    asm_nxt   = asm_c;
    key_nxt   = s1_start_r ? '0 : key_r;
    type_nxt  = type_c;
    freq_nxt  = freq_c;
    count_nxt = count_c;
    tcnt_nxt  = tcnt_c;
    fin_nxt   = fin_c;
    res_valid = 1'b0;
    res       = '0;
    if (!fin_c) begin
      pos_nxt = pos_c + 10'd1;
      if (pos_c == POS_KEY) begin
        key_nxt = s1_byte_r;
      end else if (pos_c == POS_TYPE) begin
        type_nxt = s1_byte_r;
      end else if (pos_c == POS_FREQ_HI) begin
        freq_nxt = s1_byte_r;
      end else if (pos_c == POS_FREQ_LO) begin
        freq_nxt = carrier_band({freq_c, s1_byte_r});
      end else if (pos_c == POS_COUNT_HI) begin
        asm_nxt = {16'd0, s1_byte_r};
      end else if (pos_c == POS_COUNT_LO) begin
        asm_nxt          = '0;
        res_valid        = 1'b1;
        res.kind         = KIND_HEADER;
        res.slot         = key_slot(key_r);
        res.carrier_khz  = freq_c[5:0];
        res.repeat_mode  = (type_c == TYPE_REPORT) ? RPT_REPORT :
                           (type_c == TYPE_TOGGLE) ? RPT_TOGGLE : RPT_NONE;
        res.timing_count = hdr_bad ? 9'd0 : hdr_len[8:0];
        res.bad_length   = hdr_bad;
        res.last         = hdr_bad;
        if (hdr_bad) begin
          fin_nxt = 1'b1;
        end else begin
          count_nxt = hdr_len[8:0];
        end
      end else if (pos_c >= FRAME_BASE) begin
        asm_nxt = asm_new;
        if (end_word || end_fill) begin
          asm_nxt             = '0;
          tcnt_nxt            = tcnt_c + 9'd1;
          res_valid           = 1'b1;
          res.kind            = KIND_TIMING;
          res.timing_count    = count_c;
          res.timing_index    = tcnt_c;
          res.timing_value    = div_prod[DIV10_SHIFT +: 21];
          res.in_repeat_frame = !in_main;
          if ((!in_main && q_off == 10'd7) ||
              (in_main && r_off == two_len - 10'd1 && type_c != TYPE_REPORT)) begin
            res.last = 1'b1;
            fin_nxt  = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      asm_r   <= '0;
      key_r   <= '0;
      type_r  <= '0;
      freq_r  <= '0;
      count_r <= '0;
      tcnt_r  <= '0;
      fin_r   <= 1'b1;
    end else if (advance) begin
      pos_r   <= pos_nxt;
      asm_r   <= asm_nxt;
      key_r   <= key_nxt;
      type_r  <= type_nxt;
      freq_r  <= freq_nxt;
      count_r <= count_nxt;
      tcnt_r  <= tcnt_nxt;
      fin_r   <= fin_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= res_valid;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.kind;
  assign out_tlast  = out_r.last;
  assign out_tdata  = {4'd0, out_r.bad_length, out_r.in_repeat_frame, out_r.timing_value,
                       out_r.timing_index, out_r.timing_count, out_r.repeat_mode,
                       out_r.carrier_khz, out_r.slot};

endmodule

>>> hw/rtl/irlbp_checker.sv
// Port-level checks for the learned IR blob parser and their binding.
// Depends on irlbp_pkg and on the ports of ir_learn_blob_parser_top.
module irlbp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic [7:0] in_tdata,
  input logic       in_tuser,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [irlbp_pkg::TDATA_W-1:0] out_tdata,
  input logic       out_tuser,
  input logic       out_tlast
);
  import irlbp_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result request changed");

  a_bad_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[51] |-> out_tuser == KIND_HEADER && out_tlast
      && out_tdata[19:11] == 9'd0)
    else $error("bad length result does not end the blob");

  a_header_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_HEADER |-> out_tdata[50:20] == 31'd0)
    else $error("header result carries timing fields");

  a_timing_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_TIMING |-> out_tdata[10:0] == 11'd0
      && !out_tdata[51] && out_tdata[19:11] >= 9'd4)
    else $error("timing result carries header fields");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |=> in_tvalid && $stable(in_tdata) && $stable(in_tuser))
    else $error("stalled input request changed");

endmodule

bind ir_learn_blob_parser_top irlbp_checker u_irlbp_checker (.*);
